/* rtl/core/first_fit_block_allocator_defines.svh */
// ----------------------------------------------------------------------------
// first fit block allocator assertion macros
// shared concurrent assertion forms, clocked on clock and held off in reset
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define FFBA_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("allocator implication check failed");

// condition must never be seen
`define FFBA_ASSERT_NEVER(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("allocator forbidden condition seen");

`endif

/* rtl/core/ffba_pkg.sv */
// ----------------------------------------------------------------------------
// ffba_pkg
// types and codes shared by the first fit block allocator modules
// ----------------------------------------------------------------------------
`default_nettype none

package ffba_pkg;

   // operation codes
   localparam logic [1:0] FUNC_ALLOC  = 2'd0;
   localparam logic [1:0] FUNC_ERASE  = 2'd1;
   localparam logic [1:0] FUNC_DEFRAG = 2'd2;

   // result status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NULL    = 2'd1;
   localparam logic [1:0] ST_ILLEGAL = 2'd2;

   localparam logic [15:0] MEM_SIZE_RESET = 16'hFFFF;

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] req_size;
      logic [15:0] target_id;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] new_id;
   } rsp_type;

   // one table entry
   typedef struct packed {
      logic [15:0] id;
      logic [15:0] start;
      logic [15:0] size;
   } ent_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic rd_scan;
      logic scan_step;
      logic begin_shift;
      logic rd_shift;
      logic shift_wr;
      logic put;
      logic fin_erase;
      logic set_null;
      logic set_ill;
      logic post;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] op;
      logic       alloc_ok;
      logic       at_end;
      logic       fit;
      logic       hit;
      logic       at_pos;
      logic       rsp_busy;
   } sts_type;

endpackage

`default_nettype wire

/* rtl/core/first_fit_block_allocator.sv */
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// first fit allocator over an address ordered block table with compaction
//
//   channel  ports           direction  beat
//   request  req_valid/ready in         func, req_size, target_id
//   response rsp_valid/ready out        status, new_id
//   csr      csr_we/wdata    in         memory_size, no wait
//
// erase and defragment read every entry; erase posts a response only when its
// target id misses. alloc scans to the first fitting gap and shifts later entries
// up; it answers null when nothing fits, and without a scan when no room or ids
// are left. reset is synchronous, no clearing pass; a stalled response holds the
// next beat.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_block_allocator
   import ffba_pkg::*;
#(
   parameter int MAX_BLOCKS = 16
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata
);

`include "first_fit_block_allocator_defines.svh"

   cmd_type cmd;
   sts_type sts;

   // sequencer
   ffba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // table and arithmetic
   ffba_dpath #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // a stalled response is never overwritten
   `FFBA_ASSERT_IMPL(a_post_free, cmd.post, !(rsp_valid && !rsp_ready))
   // no table read past the last entry
   `FFBA_ASSERT_IMPL(a_scan_bound, cmd.rd_scan, !sts.at_end)
   // a block is only placed while room and ids remain
   `FFBA_ASSERT_IMPL(a_put_room, cmd.put, sts.alloc_ok)
   // one result source at a time
   `FFBA_ASSERT_NEVER(a_one_result, cmd.put && (cmd.set_null || cmd.set_ill))

endmodule

`default_nettype wire

/* rtl/core/ffba_ctrl.sv */
// ----------------------------------------------------------------------------
// ffba_ctrl
// sequencer for alloc, erase and defragment over the block table
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_ctrl
   import ffba_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_DISP  = 8'b0000_0010,
      S_SC_RD = 8'b0000_0100,
      S_SC_EV = 8'b0000_1000,
      S_SH_RD = 8'b0001_0000,
      S_SH_WR = 8'b0010_0000,
      S_PUT   = 8'b0100_0000,
      S_RESP  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            case (sts.op)
               FUNC_ALLOC: begin
                  if (sts.alloc_ok) begin
                     state_in = S_SC_RD;
                  end else begin
                     cmd.set_null = 1'b1;
                     state_in     = S_RESP;
                  end
               end
               FUNC_ERASE, FUNC_DEFRAG: state_in = S_SC_RD;
               default: state_in = S_IDLE;
            endcase
         end
         S_SC_RD: begin
            if (sts.at_end) begin
               case (sts.op)
                  FUNC_ALLOC: begin
                     if (sts.fit) begin
                        cmd.begin_shift = 1'b1;
                        state_in        = S_SH_RD;
                     end else begin
                        cmd.set_null = 1'b1;
                        state_in     = S_RESP;
                     end
                  end
                  FUNC_ERASE: begin
                     cmd.fin_erase = 1'b1;
                     if (sts.hit) begin
                        state_in = S_IDLE;
                     end else begin
                        cmd.set_ill = 1'b1;
                        state_in    = S_RESP;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end else begin
               cmd.rd_scan = 1'b1;
               state_in    = S_SC_EV;
            end
         end
         S_SC_EV: begin
            if (sts.op == FUNC_ALLOC && sts.fit) begin
               cmd.begin_shift = 1'b1;
               state_in        = S_SH_RD;
            end else begin
               cmd.scan_step = 1'b1;
               state_in      = S_SC_RD;
            end
         end
         S_SH_RD: begin
            if (sts.at_pos) begin
               state_in = S_PUT;
            end else begin
               cmd.rd_shift = 1'b1;
               state_in     = S_SH_WR;
            end
         end
         S_SH_WR: begin
            cmd.shift_wr = 1'b1;
            state_in     = S_SH_RD;
         end
         S_PUT: begin
            cmd.put  = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!sts.rsp_busy) begin
               cmd.post = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

`default_nettype wire

/* rtl/core/ffba_dpath.sv */
// ----------------------------------------------------------------------------
// ffba_dpath
// block table memory, scan counters, gap check and result register
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_dpath
   import ffba_pkg::*;
#(
   parameter int MAX_BLOCKS = 16
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire req_type     req_data,
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata,
   input  wire cmd_type     cmd,
   output sts_type          sts,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data
);

   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

   ent_type mem [MAX_BLOCKS];

   logic [15:0]   mem_size_ff;
   logic [CW-1:0] count_ff;
   logic [16:0]   next_id_ff;
   logic [CW-1:0] idx_ff;
   logic [CW-1:0] wr_ff;
   logic [CW-1:0] pos_ff;
   logic [16:0]   acc_ff;
   logic          hit_ff;
   logic [1:0]    op_ff;
   logic [15:0]   size_ff;
   logic [15:0]   target_ff;
   ent_type       rd_data_ff;
   rsp_type       pend_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_data_ff;

   logic [CW-1:0] idx_m1;
   logic [16:0]   gap_hi;
   logic          gap_ok;
   logic          match;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   ent_type       wr_data;

   // gap check against the latched request size
   assign idx_m1 = idx_ff - CW'(1);
   assign gap_hi = (idx_ff == count_ff) ? {1'b0, mem_size_ff} : {1'b0, rd_data_ff.start};
   assign gap_ok = (gap_hi >= acc_ff) && ((gap_hi - acc_ff) >= {1'b0, size_ff});
   assign match  = rd_data_ff.id == target_ff;

   // status to controller
   assign sts.op       = op_ff;
   assign sts.alloc_ok = (count_ff < CW'(MAX_BLOCKS)) && !next_id_ff[16];
   assign sts.at_end   = idx_ff == count_ff;
   assign sts.fit      = gap_ok;
   assign sts.hit      = hit_ff;
   assign sts.at_pos   = idx_ff == pos_ff;
   assign sts.rsp_busy = rsp_valid_ff && !rsp_ready;

   // memory port selection
   always_comb begin
      rd_en   = cmd.rd_scan || cmd.rd_shift;
      rd_addr = cmd.rd_shift ? idx_m1[AW-1:0] : idx_ff[AW-1:0];
      wr_en   = 1'b0;
      wr_addr = idx_ff[AW-1:0];
      wr_data = rd_data_ff;
      if (cmd.scan_step && op_ff == FUNC_ERASE && !match) begin
         wr_en   = 1'b1;
         wr_addr = wr_ff[AW-1:0];
      end else if (cmd.scan_step && op_ff == FUNC_DEFRAG) begin
         wr_en         = 1'b1;
         wr_data.start = acc_ff[15:0];
      end else if (cmd.shift_wr) begin
         wr_en = 1'b1;
      end else if (cmd.put) begin
         wr_en         = 1'b1;
         wr_addr       = pos_ff[AW-1:0];
         wr_data.id    = next_id_ff[15:0];
         wr_data.start = acc_ff[15:0];
         wr_data.size  = size_ff;
      end
   end

   // table memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // request latch and scan registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_data.func;
         size_ff   <= req_data.req_size;
         target_ff <= req_data.target_id;
      end
      if (cmd.load) begin
         idx_ff <= '0;
         wr_ff  <= '0;
         acc_ff <= '0;
         hit_ff <= 1'b0;
      end else if (cmd.scan_step) begin
         idx_ff <= idx_ff + CW'(1);
         case (op_ff)
            FUNC_ALLOC: acc_ff <= {1'b0, rd_data_ff.start} + {1'b0, rd_data_ff.size};
            FUNC_ERASE: begin
               if (match) begin
                  hit_ff <= 1'b1;
               end else begin
                  wr_ff <= wr_ff + CW'(1);
               end
            end
            default: acc_ff <= {1'b0, acc_ff[15:0] + rd_data_ff.size};
         endcase
      end else if (cmd.begin_shift) begin
         pos_ff <= idx_ff;
         idx_ff <= count_ff;
      end else if (cmd.shift_wr) begin
         idx_ff <= idx_m1;
      end
   end

   // table count, id counter and size register
   always_ff @(posedge clock) begin
      if (reset) begin
         mem_size_ff <= MEM_SIZE_RESET;
         count_ff    <= '0;
         next_id_ff  <= 17'd1;
      end else begin
         if (csr_we) begin
            mem_size_ff <= csr_wdata;
         end
         if (cmd.put) begin
            count_ff   <= count_ff + CW'(1);
            next_id_ff <= next_id_ff + 17'd1;
         end else if (cmd.fin_erase) begin
            count_ff <= wr_ff;
         end
      end
   end

   // pending result
   always_ff @(posedge clock) begin
      if (cmd.set_null) begin
         pend_ff <= '{status: ST_NULL, new_id: 16'd0};
      end else if (cmd.set_ill) begin
         pend_ff <= '{status: ST_ILLEGAL, new_id: 16'd0};
      end else if (cmd.put) begin
         pend_ff <= '{status: ST_OK, new_id: next_id_ff[15:0]};
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.post) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.post) begin
         rsp_data_ff <= pend_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// first_fit_block_allocator testbench
// drives alloc, erase and defragment beats through the request channel and
// checks every response against an in-bench model of the block table
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
   import ffba_pkg::*;

   localparam int TABLE_DEPTH = 16;
   localparam int HANG_LIMIT  = 20000;
   localparam int DRAIN_WAIT  = 200;

   // operation code with no function
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   logic    csr_we;
   logic [15:0] csr_wdata;

   first_fit_block_allocator #(.MAX_BLOCKS(TABLE_DEPTH)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   // model of the block table
   logic [15:0] mdl_id    [TABLE_DEPTH];
   logic [15:0] mdl_start [TABLE_DEPTH];
   logic [15:0] mdl_size  [TABLE_DEPTH];
   int          mdl_count;
   int          mdl_next_id;
   logic [15:0] mdl_mem_size;

   rsp_type pending_rsp[$];
   int      fail_count;
   int      rsp_seen;
   int      beats_sent;
   int      idle_cycles;
   int      send_idle_pct;
   int      recv_stall_pct;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   // place a new entry at slot pos, shifting later entries up
   function automatic void table_insert(input int pos, input int start, input int size);
      for (int k = mdl_count; k > pos; k--) begin
         mdl_id[k]    = mdl_id[k-1];
         mdl_start[k] = mdl_start[k-1];
         mdl_size[k]  = mdl_size[k-1];
      end
      mdl_id[pos]    = mdl_next_id[15:0];
      mdl_start[pos] = start[15:0];
      mdl_size[pos]  = size[15:0];
      mdl_count++;
      mdl_next_id++;
   endfunction

   // first fit placement, returns new id or 0
   function automatic int place_block(input int n);
      int id;
      int lo;
      int hi;
      if (mdl_count >= TABLE_DEPTH || mdl_next_id > 65535) return 0;
      id = mdl_next_id;
      if (mdl_count == 0) begin
         if (int'(mdl_mem_size) >= n) begin
            table_insert(0, 0, n);
            return id;
         end
         return 0;
      end
      if (int'(mdl_start[0]) >= n) begin
         table_insert(0, 0, n);
         return id;
      end
      for (int k = 0; k + 1 < mdl_count; k++) begin
         lo = int'(mdl_start[k]) + int'(mdl_size[k]);
         hi = int'(mdl_start[k+1]);
         if (hi >= lo && hi - lo >= n) begin
            table_insert(k + 1, lo, n);
            return id;
         end
      end
      lo = int'(mdl_start[mdl_count-1]) + int'(mdl_size[mdl_count-1]);
      hi = int'(mdl_mem_size);
      if (hi >= lo && hi - lo >= n) begin
         table_insert(mdl_count, lo, n);
         return id;
      end
      return 0;
   endfunction

   // apply one beat to the model, queue the response it causes
   function automatic void predict_beat(input req_type b);
      rsp_type r;
      int id;
      int w;
      bit hit;
      logic [15:0] pos;
      case (b.func)
         FUNC_ALLOC: begin
            id = place_block(int'(b.req_size));
            r.status = (id != 0) ? ST_OK : ST_NULL;
            r.new_id = id[15:0];
            pending_rsp.insert(pending_rsp.size(), r);
         end
         FUNC_ERASE: begin
            w = 0;
            hit = 1'b0;
            for (int k = 0; k < mdl_count; k++) begin
               if (mdl_id[k] == b.target_id) hit = 1'b1;
               else begin
                  mdl_id[w] = mdl_id[k];
                  mdl_start[w] = mdl_start[k];
                  mdl_size[w] = mdl_size[k];
                  w++;
               end
            end
            mdl_count = w;
            if (!hit) begin
               r.status = ST_ILLEGAL;
               r.new_id = 16'd0;
               pending_rsp.insert(pending_rsp.size(), r);
            end
         end
         FUNC_DEFRAG: begin
            pos = 16'd0;
            for (int k = 0; k < mdl_count; k++) begin
               mdl_start[k] = pos;
               pos = pos + mdl_size[k];
            end
         end
         default: ;
      endcase
   endfunction

   // response checker and hang watchdog
   always @(posedge clock) begin
      if (reset) idle_cycles <= 0;
      else if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_seen <= rsp_seen + 1;
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected response status", int'(rsp_data.status), -1);
         end else begin
            if (rsp_data.status !== pending_rsp[0].status)
               report_mismatch("status", int'(rsp_data.status),
                               int'(pending_rsp[0].status));
            if (rsp_data.new_id !== pending_rsp[0].new_id)
               report_mismatch("new_id", int'(rsp_data.new_id),
                               int'(pending_rsp[0].new_id));
            void'(pending_rsp.pop_front());
         end
      end
      if (idle_cycles >= HANG_LIMIT) begin
         $display("watchdog: no progress, %0d responses outstanding", pending_rsp.size());
         $display("first_fit_block_allocator regression: fail");
         $finish;
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
   end

   // drive one beat, wait for its acceptance
   task automatic send_beat(input req_type b);
      while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) @(negedge clock);
      req_data  = b;
      req_valid = 1'b1;
      predict_beat(b);
      @(posedge clock);
      while (!(req_valid && req_ready)) @(posedge clock);
      @(negedge clock);
      beats_sent++;
      req_valid = 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic write_mem_size(input logic [15:0] v);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we    <= 1'b0;
      mdl_mem_size = v;
   endtask

   function automatic req_type mk(input logic [1:0] f, input int sz, input int tid);
      req_type b;
      b.func = f;
      b.req_size = sz[15:0];
      b.target_id = tid[15:0];
      return b;
   endfunction

   // random beat, mostly well formed against the live table
   function automatic req_type random_beat(input int size_cap);
      int pick;
      int tid;
      pick = $urandom_range(99, 0);
      if (pick < 50)
         return mk(FUNC_ALLOC, $urandom_range(size_cap, 0), $urandom);
      if (pick < 85) begin
         if (mdl_count > 0 && $urandom_range(9, 0) != 0)
            tid = mdl_id[$urandom_range(mdl_count - 1, 0)];
         else tid = $urandom;
         return mk(FUNC_ERASE, $urandom, tid);
      end
      if (pick < 97) return mk(FUNC_DEFRAG, $urandom, $urandom);
      return mk(FUNC_UNUSED, $urandom, $urandom);
   endfunction

   // directed rows: beat and, where obvious, the response typed in
   typedef struct {
      req_type beat;
      bit      has_want;
      rsp_type want;
   } row_type;

   row_type dir_rows[$];

   function automatic row_type row(input req_type b, input bit hw, input logic [1:0] st,
                                   input int id);
      row_type r;
      r.beat = b;
      r.has_want = hw;
      r.want.status = st;
      r.want.new_id = id[15:0];
      return r;
   endfunction

   function automatic void add_row(input req_type b, input bit hw, input logic [1:0] st,
                                   input int id);
      dir_rows.insert(dir_rows.size(), row(b, hw, st, id));
   endfunction

   initial begin
      int phase_cap;
      rsp_type saved;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      fail_count = 0;
      rsp_seen = 0;
      beats_sent = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      mdl_count = 0;
      mdl_next_id = 1;
      mdl_mem_size = MEM_SIZE_RESET;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table after reset, memory 65535
      add_row(mk(FUNC_ERASE, 0, 0), 1, ST_ILLEGAL, 0);
      add_row(mk(FUNC_ALLOC, 65535, 0), 1, ST_OK, 1);
      add_row(mk(FUNC_ALLOC, 1, 0), 1, ST_NULL, 0);
      add_row(mk(FUNC_ALLOC, 0, 0), 1, ST_OK, 2);
      add_row(mk(FUNC_ERASE, 0, 65535), 1, ST_ILLEGAL, 0);
      add_row(mk(FUNC_ERASE, 65535, 1), 0, ST_OK, 0);
      add_row(mk(FUNC_UNUSED, 65535, 65535), 0, ST_OK, 0);
      add_row(mk(FUNC_ALLOC, 100, 0), 0, ST_OK, 0);
      add_row(mk(FUNC_ALLOC, 200, 0), 0, ST_OK, 0);
      add_row(mk(FUNC_ERASE, 0, 3), 0, ST_OK, 0);
      add_row(mk(FUNC_ALLOC, 50, 0), 0, ST_OK, 0);
      add_row(mk(FUNC_DEFRAG, 0, 0), 0, ST_OK, 0);
      add_row(mk(FUNC_ALLOC, 65000, 0), 0, ST_OK, 0);
      for (int k = 0; k < 12; k++) add_row(mk(FUNC_ALLOC, 1, 0), 0, ST_OK, 0);
      foreach (dir_rows[i]) begin
         if (dir_rows[i].has_want) begin
            // keep the model in step, then expect the typed-in response
            predict_beat(dir_rows[i].beat);
            saved = pending_rsp.pop_back();
            if (saved != dir_rows[i].want)
               report_mismatch("directed row", int'(saved.new_id),
                               int'(dir_rows[i].want.new_id));
         end
         if (!dir_rows[i].has_want) send_beat(dir_rows[i].beat);
         else begin
            // the model already took this beat; queue the typed-in response
            pending_rsp.insert(pending_rsp.size(), dir_rows[i].want);
            req_data = dir_rows[i].beat;
            req_valid = 1'b1;
            @(posedge clock);
            while (!(req_valid && req_ready)) @(posedge clock);
            @(negedge clock);
            beats_sent++;
            req_valid = 1'b0;
         end
      end
      wait_drained();

      // memory shrunk below existing blocks
      write_mem_size(16'd10);
      send_beat(mk(FUNC_ALLOC, 1, 0));
      send_beat(mk(FUNC_DEFRAG, 0, 0));
      send_beat(mk(FUNC_ALLOC, 0, 0));
      wait_drained();

      // random phases over idling mixes and memory sizes
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
            default: begin send_idle_pct = 33; recv_stall_pct = 33; end
         endcase
         case (ph)
            0: write_mem_size(16'd0);
            1: write_mem_size(16'd65535);
            2: write_mem_size(16'd1000);
            3: write_mem_size(16'd64);
            4: write_mem_size(16'd65535);
            default: write_mem_size(16'($urandom));
         endcase
         phase_cap = (ph == 1 || ph == 4) ? 65535 :
                     (mdl_mem_size > 16'd0 ? int'(mdl_mem_size) / 4 + 1 : 3);
         for (int n = 0; n < 178; n++) begin
            send_beat(random_beat((n % 20 == 0) ? 65535 : phase_cap));
            // sender holds off until all responses are home
            if (n == 90) while (pending_rsp.size() != 0) @(negedge clock);
         end
         wait_drained();
      end

      // exhaust ids near the 16-bit limit is too slow; covered by id growth only
      $display("covered %0d request beats and %0d responses over 8 idling phases",
               beats_sent, rsp_seen);
      $display("memory sizes from 0 to 65535, full table, shrunk memory, unused func");
      if (fail_count == 0) $display("first_fit_block_allocator regression: pass");
      else $display("first_fit_block_allocator regression: fail");
      $finish;
   end

endmodule

/* first_fit_block_allocator.f */
+incdir+rtl/core
rtl/core/ffba_pkg.sv
rtl/core/ffba_ctrl.sv
rtl/core/ffba_dpath.sv
rtl/core/first_fit_block_allocator.sv
tb/sv/testbench.sv
